// ===== rtl/h_drive_motor_mixer_assert.svh =====
// ----------------------------------------------------------------------------
// H-drive motor mixer assertion macros
// Shared concurrent assertion forms for the mixer checker.
// ----------------------------------------------------------------------------
`ifndef H_DRIVE_MOTOR_MIXER_ASSERT_SVH
`define H_DRIVE_MOTOR_MIXER_ASSERT_SVH

// The consequent must follow whenever the antecedent holds.
`define HDMM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The condition must never hold.
`define HDMM_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

`endif

// ===== rtl/hdmm_pkg.sv =====
// ----------------------------------------------------------------------------
// H-drive motor mixer package
// Item types, mode codes and pipeline constants shared by the mixer files.
// ----------------------------------------------------------------------------
package hdmm_pkg;

   localparam logic [3:0] MODE_FORWARD  = 4'd0;
   localparam logic [3:0] MODE_ROTATE   = 4'd1;
   localparam logic [3:0] MODE_VEC_VEL  = 4'd2;
   localparam logic [3:0] MODE_VEC_VOLT = 4'd3;
   localparam logic [3:0] MODE_TANK     = 4'd4;
   localparam logic [3:0] MODE_ARCADE   = 4'd5;
   localparam logic [3:0] MODE_HARCADE  = 4'd6;
   localparam logic [3:0] MODE_STOP     = 4'd7;
   localparam logic [3:0] MODE_LEFT     = 4'd8;
   localparam logic [3:0] MODE_RIGHT    = 4'd9;
   localparam logic [3:0] MODE_MIDDLE   = 4'd10;

   localparam logic [1:0] REG_MAX_VELOCITY = 2'd0;
   localparam logic [1:0] REG_MAX_VOLTAGE  = 2'd1;
   localparam logic [1:0] REG_DEADBAND     = 2'd2;

   localparam logic signed [15:0] ONE_Q14    = 16'sd16384;
   localparam logic [13:0]        VOLT_LIMIT = 14'd12000;

   localparam int MOTORS       = 3;
   localparam int DIV_STEPS    = 16;
   localparam int DIV_LAT      = DIV_STEPS + 1;
   localparam int RSP_LATENCY  = DIV_LAT + 3;

   typedef struct packed {
      logic [3:0]         req_type;
      logic signed [15:0] primary_cmd;
      logic signed [15:0] secondary_cmd;
      logic signed [15:0] strafe_cmd;
   } hdmm_req_type;

   typedef struct packed {
      logic signed [15:0] left_value;
      logic               left_is_voltage;
      logic               left_valid;
      logic signed [15:0] right_value;
      logic               right_is_voltage;
      logic               right_valid;
      logic signed [15:0] middle_value;
      logic               middle_is_voltage;
      logic               middle_valid;
   } hdmm_rsp_type;

   typedef struct packed {
      logic [14:0] max_velocity;
      logic [13:0] max_voltage;
      logic [14:0] deadband;
   } hdmm_cfg_type;

   typedef struct packed {
      logic        neg;
      logic [15:0] mag;
      logic [14:0] full;
   } hdmm_lane_type;

   typedef struct packed {
      logic [MOTORS-1:0] volt;
      logic [MOTORS-1:0] motor_valid;
   } hdmm_meta_type;

endpackage

// ===== rtl/h_drive_motor_mixer.sv =====
// ----------------------------------------------------------------------------
// H-drive motor mixer
// Each item passes the input register, the mixing stage, the divider and the
// result register in turn.
// Throughput: one item per cycle; busy stays low since every stage advances.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Synchronous reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module h_drive_motor_mixer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  hdmm_pkg::hdmm_req_type req_data,
   output logic                   rsp_strobe,
   output hdmm_pkg::hdmm_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data
);
   import hdmm_pkg::*;

   hdmm_cfg_type               cfg_ff;
   logic                       in_valid_ff;
   hdmm_req_type               in_ff, in_in;
   logic                       mix_valid;
   hdmm_lane_type [MOTORS-1:0] mix_lane;
   logic [15:0]                mix_div;
   hdmm_meta_type              mix_meta;
   logic                       vld_ff  [0:DIV_LAT-1];
   hdmm_meta_type              meta_ff [0:DIV_LAT-1];
   logic [15:0]                quo     [0:MOTORS-1];
   logic                       neg     [0:MOTORS-1];
   logic signed [15:0]         val     [0:MOTORS-1];
   logic                       strobe_ff;
   hdmm_rsp_type               rsp_ff, rsp_in;

   function automatic logic signed [15:0] clamp_in(input logic signed [15:0] v);
      if (v > ONE_Q14) return ONE_Q14;
      if (v < -ONE_Q14) return -ONE_Q14;
      return v;
   endfunction

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_velocity <= 15'd600;
         cfg_ff.max_voltage  <= VOLT_LIMIT;
         cfg_ff.deadband     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAX_VELOCITY: cfg_ff.max_velocity <= csr_data[14:0];
            REG_MAX_VOLTAGE: begin
               cfg_ff.max_voltage <= (csr_data[13:0] > VOLT_LIMIT) ? VOLT_LIMIT
                                                                   : csr_data[13:0];
            end
            REG_DEADBAND:     cfg_ff.deadband <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_in               = req_data;
      in_in.primary_cmd   = clamp_in(req_data.primary_cmd);
      in_in.secondary_cmd = clamp_in(req_data.secondary_cmd);
      in_in.strafe_cmd    = clamp_in(req_data.strafe_cmd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
      in_ff <= in_in;
   end

   hdmm_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_item   (in_ff),
      .cfg       (cfg_ff),
      .out_valid (mix_valid),
      .out_lane  (mix_lane),
      .out_div   (mix_div),
      .out_meta  (mix_meta)
   );

   for (genvar k = 0; k < MOTORS; k++) begin : g_lane
      hdmm_div u_div (
         .clock   (clock),
         .in_lane (mix_lane[k]),
         .in_div  (mix_div),
         .out_quo (quo[k]),
         .out_neg (neg[k])
      );
      always_comb begin
         if (neg[k]) begin
            val[k] = (quo[k] > 16'd32768) ? -16'sd32768 : 16'(-{1'b0, quo[k]});
         end else begin
            val[k] = (quo[k] > 16'd32767) ? 16'sd32767 : $signed(quo[k]);
         end
      end
   end

   // Item flags ride alongside the divider so they line up with its quotient.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= mix_valid;
         for (int i = 1; i < DIV_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
      meta_ff[0] <= mix_meta;
      for (int i = 1; i < DIV_LAT; i++) meta_ff[i] <= meta_ff[i-1];
   end

   always_comb begin
      hdmm_meta_type mt;
      mt                       = meta_ff[DIV_LAT-1];
      rsp_in.left_value        = val[0];
      rsp_in.left_is_voltage   = mt.volt[0];
      rsp_in.left_valid        = mt.motor_valid[0];
      rsp_in.right_value       = val[1];
      rsp_in.right_is_voltage  = mt.volt[1];
      rsp_in.right_valid       = mt.motor_valid[1];
      rsp_in.middle_value      = val[2];
      rsp_in.middle_is_voltage = mt.volt[2];
      rsp_in.middle_valid      = mt.motor_valid[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_ff[DIV_LAT-1];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== rtl/hdmm_mix.sv =====
// ----------------------------------------------------------------------------
// H-drive motor mixer mixing stage
// Deadband, mode mixing and divisor selection, registered once.
// ----------------------------------------------------------------------------
module hdmm_mix (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  hdmm_pkg::hdmm_req_type        in_item,
   input  hdmm_pkg::hdmm_cfg_type        cfg,
   output logic                          out_valid,
   output hdmm_pkg::hdmm_lane_type [2:0] out_lane,
   output logic [15:0]                   out_div,
   output hdmm_pkg::hdmm_meta_type       out_meta
);
   import hdmm_pkg::*;

   logic                          valid_ff;
   hdmm_lane_type [MOTORS-1:0]    lane_ff, lane_in;
   logic [15:0]                   div_ff, div_in;
   hdmm_meta_type                 meta_ff, meta_in;

   function automatic logic [17:0] abs18(input logic signed [17:0] v);
      return v[17] ? 18'(-v) : 18'(v);
   endfunction

   function automatic logic signed [17:0] clamp1(input logic signed [17:0] v);
      if (v > 18'sd16384) return 18'sd16384;
      if (v < -18'sd16384) return -18'sd16384;
      return v;
   endfunction

   function automatic hdmm_lane_type mk_lane(input logic signed [17:0] v,
                                             input logic [14:0] full);
      hdmm_lane_type l;
      logic [17:0]   a;
      a      = abs18(v);
      l.neg  = v[17];
      l.mag  = a[15:0];
      l.full = full;
      return l;
   endfunction

   always_comb begin
      logic signed [17:0] p, s, x, f, y, h, l, r, mi;
      logic [17:0]        am, bm, m;
      logic [17:0]        db;
      logic [14:0]        vel, volt;
      p    = 18'(in_item.primary_cmd);
      s    = 18'(in_item.secondary_cmd);
      x    = 18'(in_item.strafe_cmd);
      db   = 18'(cfg.deadband);
      vel  = cfg.max_velocity;
      volt = 15'(cfg.max_voltage);
      f = p; y = s; h = x; l = '0; r = '0; mi = '0; am = '0; bm = '0; m = '0;
      lane_in = '0;
      div_in  = 16'(ONE_Q14);
      meta_in = '0;
      case (in_item.req_type)
         MODE_FORWARD: begin
            meta_in.motor_valid = '1;
            lane_in[0] = mk_lane(p, vel);
            lane_in[1] = mk_lane(p, vel);
         end
         MODE_ROTATE: begin
            meta_in.motor_valid = '1;
            lane_in[0] = mk_lane(p, vel);
            lane_in[1] = mk_lane(-p, vel);
         end
         MODE_VEC_VEL, MODE_VEC_VOLT: begin
            meta_in.motor_valid = '1;
            l  = p + s;
            r  = p - s;
            am = abs18(l);
            bm = abs18(r);
            m  = (am > bm) ? am : bm;
            if (m > 18'd16384) div_in = m[15:0];
            if (in_item.req_type == MODE_VEC_VOLT) begin
               meta_in.volt = 3'b011;
               lane_in[0]   = mk_lane(l, volt);
               lane_in[1]   = mk_lane(r, volt);
            end else begin
               lane_in[0] = mk_lane(l, vel);
               lane_in[1] = mk_lane(r, vel);
            end
         end
         MODE_TANK: begin
            meta_in.motor_valid = '1;
            meta_in.volt        = 3'b011;
            if (abs18(p) < db) f = '0;
            if (abs18(s) < db) y = '0;
            lane_in[0] = mk_lane(f, volt);
            lane_in[1] = mk_lane(y, volt);
         end
         MODE_ARCADE: begin
            meta_in.motor_valid = '1;
            meta_in.volt        = 3'b011;
            if (abs18(p) <= db) f = '0;
            if (abs18(s) <= db) y = '0;
            am = abs18(f);
            bm = abs18(y);
            mi = (am > bm) ? $signed(am) : $signed(bm);
            if (f[17]) mi = -mi;
            // Same-sign quadrants drive left at the larger magnitude.
            if (f[17] == y[17]) begin
               l = mi;
               r = f - y;
            end else begin
               l = f + y;
               r = mi;
            end
            lane_in[0] = mk_lane(clamp1(l), volt);
            lane_in[1] = mk_lane(clamp1(r), volt);
         end
         MODE_HARCADE: begin
            meta_in.motor_valid = '1;
            meta_in.volt        = 3'b111;
            if (abs18(p) < db) f = '0;
            if (abs18(s) < db) y = '0;
            if (abs18(x) < db) h = '0;
            lane_in[0] = mk_lane(clamp1(f + y), volt);
            lane_in[1] = mk_lane(clamp1(f - y), volt);
            lane_in[2] = mk_lane(h, volt);
         end
         MODE_STOP: begin
            meta_in.motor_valid = '1;
         end
         MODE_LEFT: begin
            meta_in.motor_valid = 3'b001;
            lane_in[0] = mk_lane(p, vel);
         end
         MODE_RIGHT: begin
            meta_in.motor_valid = 3'b010;
            lane_in[1] = mk_lane(p, vel);
         end
         MODE_MIDDLE: begin
            meta_in.motor_valid = 3'b100;
            lane_in[2] = mk_lane(p, vel);
         end
         default: begin
            meta_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      lane_ff <= lane_in;
      div_ff  <= div_in;
      meta_ff <= meta_in;
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_div   = div_ff;
   assign out_meta  = meta_ff;

endmodule

// ===== rtl/hdmm_div.sv =====
// ----------------------------------------------------------------------------
// H-drive motor mixer scaling lane
// Multiplies magnitude by full scale, then a restoring divide, one bit a stage.
// ----------------------------------------------------------------------------
module hdmm_div (
   input  logic                    clock,
   input  hdmm_pkg::hdmm_lane_type in_lane,
   input  logic [15:0]             in_div,
   output logic [15:0]             out_quo,
   output logic                    out_neg
);
   import hdmm_pkg::*;

   logic [30:0]          rem_ff [0:DIV_STEPS-1];
   logic [15:0]          quo_ff [0:DIV_STEPS];
   logic [15:0]          div_ff [0:DIV_STEPS-1];
   logic                 neg_ff [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      rem_ff[0] <= 31'(in_lane.mag * in_lane.full);
      quo_ff[0] <= '0;
      div_ff[0] <= in_div;
      neg_ff[0] <= in_lane.neg;
   end

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [31:0] trial;
      logic        take;
      assign trial = 32'(div_ff[i]) << (DIV_STEPS - 1 - i);
      assign take  = {1'b0, rem_ff[i]} >= trial;
      always_ff @(posedge clock) begin
         quo_ff[i+1] <= {quo_ff[i][14:0], take};
         neg_ff[i+1] <= neg_ff[i];
      end
      // The last step only needs its quotient bit.
      if (i < DIV_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[i+1] <= take ? 31'({1'b0, rem_ff[i]} - trial) : rem_ff[i];
            div_ff[i+1] <= div_ff[i];
         end
      end
   end

   assign out_quo = quo_ff[DIV_STEPS];
   assign out_neg = neg_ff[DIV_STEPS];

endmodule

// ===== rtl/hdmm_checker.sv =====
// ----------------------------------------------------------------------------
// H-drive motor mixer checker
// Port-level timing and result consistency checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "h_drive_motor_mixer_assert.svh"

module hdmm_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input hdmm_pkg::hdmm_rsp_type rsp_data
);
   import hdmm_pkg::*;

   `HDMM_ASSERT_IMPL(a_item_gives_result, clock, reset, start && !busy, ##RSP_LATENCY rsp_strobe)
   `HDMM_ASSERT_IMPL(a_result_had_item, clock, reset, rsp_strobe, $past(start && !busy, RSP_LATENCY))
   `HDMM_ASSERT_IMPL(a_idle_left_zero, clock, reset, rsp_strobe && !rsp_data.left_valid, rsp_data.left_value == 16'sd0 && !rsp_data.left_is_voltage)
   `HDMM_ASSERT_IMPL(a_volt_mid_all, clock, reset, rsp_strobe && rsp_data.middle_is_voltage, rsp_data.left_is_voltage && rsp_data.right_is_voltage)

endmodule

bind h_drive_motor_mixer hdmm_checker u_hdmm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
